// ----- sv/mia_pkg.sv -----
// ----------------------------------------------------------------------------
// mia_pkg: shared constants for the 4x4 adjugate inverse
// Widths of the fixed-point operands, products and accumulators.
// ----------------------------------------------------------------------------
package mia_pkg;

  // Fraction bits of the fixed-point element format.
  localparam int FRAC_BITS = 16;

  localparam int ELEM_W = 32;
  localparam int EPS_W  = 31;

  // Shared multiplier: signed 33 x signed 36.
  localparam int MUL_A_W = ELEM_W + 1;
  localparam int MUL_B_W = 36;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // 2x2 minor, 3x3 cofactor and determinant widths.
  localparam int D2_W  = 2 * ELEM_W + 1;
  localparam int ACC_W = 100;
  localparam int DET_W = 134;

  // Dividend bits fed through the restoring divider.
  localparam int NUM_W     = ACC_W + 2 * FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  // Last multiply step of a cofactor, and of a top-row cofactor that also
  // feeds the determinant.
  localparam logic [3:0] STEP_COF_LAST = 4'd11;
  localparam logic [3:0] STEP_DET_LAST = 4'd14;

endpackage

// ----- sv/mia_ram.sv -----
// ----------------------------------------------------------------------------
// mia_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/matrix4_adjugate_inverse.sv -----
// ----------------------------------------------------------------------------
// matrix4_adjugate_inverse: 4x4 matrix inverse by adjugate, Q16.16
// Loads 16 elements one beat per cycle, forms cofactors and determinant with
// one shared 33x36 multiplier, then divides each cofactor bit-serially in the
// restoring divider (132 steps); a singular matrix skips the divider and
// returns its input elements unchanged.
// A new load starts only after the sixteenth result has entered the output
// register.
// Reset (synchronous, rst_n low) clears the load count, the sequencer, the
// output valid and det_epsilon; the element store is not cleared.
// ----------------------------------------------------------------------------
module matrix4_adjugate_inverse (
  input  logic        clk,
  input  logic        rst_n,
  // Input beats.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] elem_value
  // Result beats.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [3:0] elem_index, [35:4] result_value, zero pad
  output logic        out_tuser,   // [0] singular
  output logic        out_tlast,
  // Configuration.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  import mia_pkg::*;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_FETCH = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_DABS  = 4'd3;
  localparam logic [3:0] S_DCMP  = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_RDW   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_FIX   = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0] state_r;
  logic [3:0] load_cnt_r;
  logic [EPS_W-1:0] eps_r;

  logic [3:0] cof_idx_r;
  logic [3:0] fetch_cnt_r;
  logic [3:0] step_r;
  logic       phase_r;
  logic [ELEM_W-1:0] m_r [10];

  logic signed [PROD_W-1:0] p_r;
  logic signed [D2_W-1:0]   d_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  cof_r;
  logic signed [DET_W-1:0]  det_r;
  logic [DET_W-1:0] dmag_r;
  logic             det_neg_r;
  logic             sing_r;

  logic [3:0]           out_idx_r;
  logic                 neg_r;
  logic [NUM_W-1:0]     num_r;
  logic [DET_W-1:0]     rem_r;
  logic [ELEM_W-1:0]    q_r;
  logic                 ovf_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [ELEM_W-1:0]    res_r;

  logic              out_valid_r;
  logic [3:0]        out_index_r;
  logic [ELEM_W-1:0] out_value_r;
  logic              out_sing_r;
  logic              out_last_r;

  logic [1:0] row_i, col_j;
  assign row_i = cof_idx_r[3:2];
  assign col_j = cof_idx_r[1:0];

  // Store address of minor element n of cofactor (i, j); slot 9 is a[0][j].
  function automatic logic [3:0] minor_addr(input logic [1:0] i, input logic [1:0] j,
                                            input logic [3:0] n);
    logic [1:0] a, b, r, c;
    a = 2'd0;
    b = 2'd0;
    unique case (n)
      4'd0: begin a = 2'd0; b = 2'd0; end
      4'd1: begin a = 2'd0; b = 2'd1; end
      4'd2: begin a = 2'd0; b = 2'd2; end
      4'd3: begin a = 2'd1; b = 2'd0; end
      4'd4: begin a = 2'd1; b = 2'd1; end
      4'd5: begin a = 2'd1; b = 2'd2; end
      4'd6: begin a = 2'd2; b = 2'd0; end
      4'd7: begin a = 2'd2; b = 2'd1; end
      4'd8: begin a = 2'd2; b = 2'd2; end
      default: begin a = 2'd0; b = 2'd0; end
    endcase
    r = (a >= i) ? a + 2'd1 : a;
    c = (b >= j) ? b + 2'd1 : b;
    if (n == 4'd9) begin
      minor_addr = {2'd0, j};
    end else begin
      minor_addr = {r, c};
    end
  endfunction

  // Element and cofactor stores.
  logic              in_fire;
  logic [3:0]        elem_raddr;
  logic [ELEM_W-1:0] elem_rdata;
  logic              cof_we;
  logic [ACC_W-1:0]  cof_wdata;
  logic [ACC_W-1:0]  cof_rdata;

  assign in_tready  = (state_r == S_LOAD);
  assign in_fire    = in_tvalid && in_tready;
  assign elem_raddr = (state_r == S_FETCH) ? minor_addr(row_i, col_j, fetch_cnt_r)
                                           : out_idx_r;

  mia_ram #(.WIDTH(ELEM_W), .DEPTH(16)) u_elem_ram (
    .clk   (clk),
    .we    (in_fire),
    .waddr (load_cnt_r),
    .wdata (in_tdata),
    .raddr (elem_raddr),
    .rdata (elem_rdata)
  );

  // Cofactor (i, j) is kept at j*4+i, the row-major place of its inverse term.
  mia_ram #(.WIDTH(ACC_W), .DEPTH(16)) u_cof_ram (
    .clk   (clk),
    .we    (cof_we),
    .waddr ({col_j, row_i}),
    .wdata (cof_wdata),
    .raddr (out_idx_r),
    .rdata (cof_rdata)
  );

  // Operand selection for the shared multiplier.
  logic [ELEM_W-1:0]         opa;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [PROD_W-1:0]  prod;

  always_comb begin
    opa   = m_r[0];
    mul_b = '0;
    unique case (step_r)
      4'd0:  begin opa = m_r[4]; mul_b = MUL_B_W'($signed(m_r[8])); end
      4'd1:  begin opa = m_r[5]; mul_b = MUL_B_W'($signed(m_r[7])); end
      4'd4:  begin opa = m_r[5]; mul_b = MUL_B_W'($signed(m_r[6])); end
      4'd5:  begin opa = m_r[3]; mul_b = MUL_B_W'($signed(m_r[8])); end
      4'd8:  begin opa = m_r[3]; mul_b = MUL_B_W'($signed(m_r[7])); end
      4'd9:  begin opa = m_r[4]; mul_b = MUL_B_W'($signed(m_r[6])); end
      4'd2:  begin opa = m_r[0]; mul_b = {4'd0, d_r[31:0]}; end
      4'd3:  begin opa = m_r[0]; mul_b = {{3{d_r[D2_W-1]}}, d_r[D2_W-1:32]}; end
      4'd6:  begin opa = m_r[1]; mul_b = {4'd0, d_r[31:0]}; end
      4'd7:  begin opa = m_r[1]; mul_b = {{3{d_r[D2_W-1]}}, d_r[D2_W-1:32]}; end
      4'd10: begin opa = m_r[2]; mul_b = {4'd0, d_r[31:0]}; end
      4'd11: begin opa = m_r[2]; mul_b = {{3{d_r[D2_W-1]}}, d_r[D2_W-1:32]}; end
      4'd12: begin opa = m_r[9]; mul_b = {4'd0, cof_r[31:0]}; end
      4'd13: begin opa = m_r[9]; mul_b = {4'd0, cof_r[63:32]}; end
      4'd14: begin opa = m_r[9]; mul_b = cof_r[ACC_W-1:64]; end
      default: begin opa = m_r[0]; mul_b = '0; end
    endcase
    mul_a = {opa[ELEM_W-1], opa};
  end

  assign prod = mul_a * mul_b;

  // Accumulation paths fed from the product register.
  logic signed [ACC_W-1:0] p_acc;
  logic signed [DET_W-1:0] p_det;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] cof_nxt;

  assign p_acc = {{(ACC_W-PROD_W){p_r[PROD_W-1]}}, p_r};
  assign p_det = {{(DET_W-PROD_W){p_r[PROD_W-1]}}, p_r};

  always_comb begin
    acc_nxt = acc_r;
    if (step_r[1:0] == 2'd2) begin
      acc_nxt = acc_r + p_acc;
    end else if (step_r[1:0] == 2'd3) begin
      acc_nxt = acc_r + (p_acc <<< 32);
    end
    cof_nxt = (row_i[0] ^ col_j[0]) ? -acc_nxt : acc_nxt;
  end

  assign cof_we    = (state_r == S_MUL) && phase_r && (step_r == STEP_COF_LAST);
  assign cof_wdata = cof_nxt;

  // Divider datapath and determinant threshold.
  logic signed [ACC_W-1:0] cof_s;
  logic [ACC_W-1:0] cmag;
  logic [DET_W-1:0] rem_sh;
  logic             rem_ge;
  logic [DET_W-1:0] eps_lim;

  assign cof_s   = cof_rdata;
  assign cmag    = cof_s[ACC_W-1] ? ACC_W'(-cof_s) : cof_rdata;
  assign rem_sh  = {rem_r[DET_W-2:0], num_r[NUM_W-1]};
  assign rem_ge  = (rem_sh >= dmag_r);
  assign eps_lim = {{(DET_W-EPS_W){1'b0}}, eps_r} << (3 * FRAC_BITS);

  logic emit_fire;
  assign emit_fire = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  // Sequencer and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      load_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_LOAD: begin
          if (in_fire) begin
            load_cnt_r <= load_cnt_r + 4'd1;
            if (load_cnt_r == 4'd15) begin
              state_r <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          if (fetch_cnt_r == 4'd10) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (phase_r) begin
            if ((step_r == STEP_COF_LAST && row_i != 2'd0) || step_r == STEP_DET_LAST) begin
              state_r <= (cof_idx_r == 4'd15) ? S_DABS : S_FETCH;
            end
          end
        end
        S_DABS: state_r <= S_DCMP;
        S_DCMP: state_r <= S_RD;
        S_RD:   state_r <= S_RDW;
        S_RDW:  state_r <= sing_r ? S_EMIT : S_DIV;
        S_DIV: begin
          if (div_cnt_r == DIV_CNT_W'(NUM_W - 1)) begin
            state_r <= S_FIX;
          end
        end
        S_FIX: state_r <= S_EMIT;
        S_EMIT: begin
          if (emit_fire) begin
            state_r <= (out_idx_r == 4'd15) ? S_LOAD : S_RD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]) begin
      eps_r <= cfg_pwdata[EPS_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {1'b0, eps_r};

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_LOAD: begin
        if (in_fire && load_cnt_r == 4'd15) begin
          cof_idx_r   <= '0;
          fetch_cnt_r <= '0;
          det_r       <= '0;
        end
      end
      S_FETCH: begin
        if (fetch_cnt_r != 4'd0) begin
          m_r[fetch_cnt_r - 4'd1] <= elem_rdata;
        end
        fetch_cnt_r <= fetch_cnt_r + 4'd1;
        step_r      <= '0;
        phase_r     <= 1'b0;
        acc_r       <= '0;
      end
      S_MUL: begin
        if (!phase_r) begin
          p_r     <= prod;
          phase_r <= 1'b1;
        end else begin
          phase_r <= 1'b0;
          if (step_r <= STEP_COF_LAST) begin
            unique case (step_r[1:0])
              2'd0: d_r <= p_r[D2_W-1:0];
              2'd1: d_r <= d_r - p_r[D2_W-1:0];
              2'd2: acc_r <= acc_nxt;
              2'd3: acc_r <= acc_nxt;
              default: acc_r <= acc_nxt;
            endcase
          end else if (step_r == 4'd12) begin
            det_r <= det_r + p_det;
          end else if (step_r == 4'd13) begin
            det_r <= det_r + (p_det <<< 32);
          end else begin
            det_r <= det_r + (p_det <<< 64);
          end
          if (step_r == STEP_COF_LAST) begin
            cof_r <= cof_nxt;
          end
          if ((step_r == STEP_COF_LAST && row_i != 2'd0) || step_r == STEP_DET_LAST) begin
            cof_idx_r   <= cof_idx_r + 4'd1;
            fetch_cnt_r <= '0;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
      end
      S_DABS: begin
        det_neg_r <= det_r[DET_W-1];
        dmag_r    <= det_r[DET_W-1] ? DET_W'(-det_r) : det_r;
      end
      S_DCMP: begin
        sing_r    <= (dmag_r <= eps_lim);
        out_idx_r <= '0;
      end
      S_RD: begin
      end
      S_RDW: begin
        neg_r     <= cof_s[ACC_W-1] ^ det_neg_r;
        res_r     <= elem_rdata;
        num_r     <= {cmag, {(2 * FRAC_BITS){1'b0}}};
        rem_r     <= '0;
        q_r       <= '0;
        ovf_r     <= 1'b0;
        div_cnt_r <= '0;
      end
      S_DIV: begin
        num_r     <= num_r << 1;
        rem_r     <= rem_ge ? rem_sh - dmag_r : rem_sh;
        q_r       <= {q_r[ELEM_W-2:0], rem_ge};
        ovf_r     <= ovf_r | q_r[ELEM_W-1];
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end
      S_FIX: begin
        // Saturate to the signed 32-bit range.
        if (neg_r) begin
          if (ovf_r || (q_r[ELEM_W-1] && q_r[ELEM_W-2:0] != '0)) begin
            res_r <= {1'b1, {(ELEM_W-1){1'b0}}};
          end else begin
            res_r <= -q_r;
          end
        end else begin
          if (ovf_r || q_r[ELEM_W-1]) begin
            res_r <= {1'b0, {(ELEM_W-1){1'b1}}};
          end else begin
            res_r <= q_r;
          end
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          out_index_r <= out_idx_r;
          out_value_r <= res_r;
          out_sing_r  <= sing_r;
          out_last_r  <= (out_idx_r == 4'd15);
          out_idx_r   <= out_idx_r + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_value_r, out_index_r};
  assign out_tuser  = out_sing_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- tb/matrix4_adjugate_inverse_tb.sv -----
// ----------------------------------------------------------------------------
// matrix4_adjugate_inverse_tb: self-checking bench for the 4x4 inverse
// Streams whole matrices into the block, predicts each of the 16 result beats
// with exact wide arithmetic, and compares every result beat in order. The
// bench runs under several det_epsilon settings and idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module matrix4_adjugate_inverse_tb;
  import mia_pkg::*;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [3:0]  index;
    logic [31:0] value;
    logic        sing;
    logic        last;
  } inv_beat_t;

  localparam int WATCHDOG_LIMIT = 40000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predictor state.
  logic [31:0]     mat_store [16];
  int unsigned     load_pos = 0;
  logic [EPS_W-1:0] eps_shadow = '0;
  inv_beat_t       pending_beats [$];

  int unsigned in_idle_pct = 0;
  int unsigned out_idle_pct = 0;
  int          fail_count = 0;
  int          quiet_cycles = 0;

  matrix4_adjugate_inverse dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic wide_t stored_elem(int idx);
    return wide_t'($signed(mat_store[idx]));
  endfunction

  // Signed cofactor of (row, col) from the 3x3 minor.
  function automatic wide_t cofactor_of(int row, int col);
    wide_t e [3][3];
    wide_t s;
    int ri;
    int ci;
    ri = 0;
    for (int i = 0; i < 4; i++) begin
      if (i != row) begin
        ci = 0;
        for (int j = 0; j < 4; j++) begin
          if (j != col) begin
            e[ri][ci] = stored_elem(i * 4 + j);
            ci++;
          end
        end
        ri++;
      end
    end
    s = e[0][0] * e[1][1] * e[2][2] + e[0][1] * e[1][2] * e[2][0]
      + e[0][2] * e[1][0] * e[2][1] - e[0][0] * e[1][2] * e[2][1]
      - e[0][1] * e[1][0] * e[2][2] - e[0][2] * e[1][1] * e[2][0];
    return ((row + col) % 2 == 1) ? -s : s;
  endfunction

  // Queue the 16 inverse beats of the stored matrix.
  task automatic predict_inverse();
    wide_t cof [4][4];
    wide_t det;
    wide_t det_mag;
    wide_t cof_mag;
    wide_t quot;
    wide_t eps_lim;
    logic  sing;
    logic  neg;
    inv_beat_t b;
    det = '0;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) cof[i][j] = cofactor_of(i, j);
    for (int j = 0; j < 4; j++) det = det + stored_elem(j) * cof[0][j];
    det_mag = det[255] ? -det : det;
    eps_lim = wide_t'({1'b0, eps_shadow}) <<< (3 * FRAC_BITS);
    sing = ($unsigned(det_mag) <= $unsigned(eps_lim));
    for (int k = 0; k < 16; k++) begin
      b.index = 4'(k);
      b.sing  = sing;
      b.last  = (k == 15);
      if (sing) begin
        b.value = mat_store[k];
      end else begin
        cof_mag = cof[k % 4][k / 4][255] ? -cof[k % 4][k / 4] : cof[k % 4][k / 4];
        neg = cof[k % 4][k / 4][255] != det[255];
        quot = wide_t'($unsigned(cof_mag <<< (2 * FRAC_BITS)) / $unsigned(det_mag));
        if (neg)
          b.value = ($unsigned(quot) <= 256'h8000_0000) ? 32'(-quot) : 32'h8000_0000;
        else
          b.value = ($unsigned(quot) <= 256'h7FFF_FFFF) ? quot[31:0] : 32'h7FFF_FFFF;
      end
      pending_beats.push_back(b);
    end
  endtask

  // Receiver stall pattern.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // Result checking and inactivity watchdog.
  always @(posedge clk) begin
    inv_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected result beat tdata=%h tuser=%b tlast=%b",
                 $time, out_tdata, out_tuser, out_tlast);
        fail_count++;
      end else begin
        want = pending_beats.pop_front();
        if (out_tdata[3:0] !== want.index || out_tdata[35:4] !== want.value ||
            out_tuser !== want.sing || out_tlast !== want.last) begin
          $display("%0t: mismatch expected idx=%0d val=%h sing=%b last=%b",
                   $time, want.index, want.value, want.sing, want.last);
          $display("%0t:          actual   idx=%0d val=%h sing=%b last=%b",
                   $time, out_tdata[3:0], out_tdata[35:4], out_tuser, out_tlast);
          fail_count++;
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Send one element beat; tvalid stays high for a following beat.
  task automatic send_elem(logic [31:0] val);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= val;
    do @(posedge clk); while (!in_tready);
    mat_store[load_pos] = val;
    if (load_pos == 15) begin
      load_pos = 0;
      predict_inverse();
    end else begin
      load_pos++;
    end
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_epsilon(logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    eps_shadow = val[EPS_W-1:0];
    @(posedge clk);
  endtask

  task automatic test_identity();
    for (int k = 0; k < 16; k++) send_elem((k % 5 == 0) ? 32'h0001_0000 : 32'h0);
    drain();
  endtask

  // Field extremes scattered over a matrix.
  task automatic test_extremes();
    logic [31:0] pick [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001};
    for (int k = 0; k < 16; k++) send_elem(pick[(k + k / 4) % 4]);
    drain();
  endtask

  // One random matrix of a random kind.
  task automatic send_random_matrix();
    logic [31:0] m [16];
    int kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 16; k++) begin
      case (kind)
        0, 1, 2, 3: begin
          m[k] = 32'($signed($urandom_range(0, 32'h1_0000)) - 32'sh8000);
          if (k % 5 == 0) m[k] = m[k] + 32'($urandom_range(1, 4)) * 32'h1_0000;
        end
        4, 5: m[k] = $urandom();
        6: m[k] = 32'($signed($urandom_range(0, 8)) - 4);
        7: m[k] = (k >= 12) ? m[k - 12] : $urandom();
        8: m[k] = 32'($signed($urandom_range(0, 200)) - 100) <<< $urandom_range(0, 20);
        default: begin
          case ($urandom_range(0, 4))
            0: m[k] = 32'h8000_0000;
            1: m[k] = 32'h7FFF_FFFF;
            2: m[k] = 32'h0;
            3: m[k] = 32'hFFFF_FFFF;
            default: m[k] = 32'h0001_0000;
          endcase
        end
      endcase
    end
    for (int k = 0; k < 16; k++) send_elem(m[k]);
  endtask

  task automatic test_random_phase(int matrices);
    for (int n = 0; n < matrices; n++) begin
      send_random_matrix();
      // Hold off now and then until the pipeline has emptied.
      if ($urandom_range(0, 3) == 0) drain();
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_epsilon(32'h0);
    in_idle_pct = 14;
    out_idle_pct = 49;
    test_identity();
    test_extremes();
    test_random_phase(4);
    // Upper bit is outside the register and must be dropped.
    write_epsilon(32'h8000_0001);
    in_idle_pct = 49;
    out_idle_pct = 14;
    test_random_phase(4);
    write_epsilon(32'h7FFF_FFFF);
    in_idle_pct = 0;
    out_idle_pct = 0;
    test_identity();
    test_random_phase(1);
    write_epsilon($urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 30));
    test_random_phase(2);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
